### rtl/bffa_pkg.sv
// shared types, constants and widths for the bitmap first-fit word allocator
package bffa_pkg;

   localparam int HEAP_WORDS_DEF = 1024;
   localparam int ROW_BITS       = 32;
   localparam int ROW_SHIFT      = 5;
   localparam int COUNT_W        = 11;
   localparam int INDEX_W        = 10;
   localparam int QUEUE_AW       = 1;
   localparam int QUEUE_DEPTH    = 1 << QUEUE_AW;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_REJECT = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [COUNT_W-1:0]   count;
      logic [INDEX_W-1:0]   index;
   } cmd_type;

   // queue head seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   // back end status seen by the front end
   typedef struct packed {
      logic clearing;
      logic take;
   } back_status_type;

endpackage

### rtl/bffa_if.sv
// request and response channel interfaces
interface bffa_req_if;
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic [bffa_pkg::COUNT_W-1:0] word_count;
   logic [bffa_pkg::INDEX_W-1:0] block_index;

   modport source (output valid, output op, output word_count, output block_index,
                   input ready);
   modport sink   (input valid, input op, input word_count, input block_index,
                   output ready);
endinterface

interface bffa_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         ok;
   logic [bffa_pkg::INDEX_W-1:0] start_index;

   modport source (output valid, output ok, output start_index, input ready);
   modport sink   (input valid, input ok, input start_index, output ready);
endinterface

### rtl/bffa_ram.sv
// generic single-port ram with registered read
module bffa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                       wdata,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write or read one row
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

### rtl/bffa_front.sv
// front end: request classification and two-entry command queue
module bffa_front #(
   parameter int HEAP_WORDS = bffa_pkg::HEAP_WORDS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   bffa_req_if.sink                   req_bus,
   input  bffa_pkg::back_status_type  status,
   output bffa_pkg::queue_head_type   head
);
   bffa_pkg::cmd_type                   q_ff [bffa_pkg::QUEUE_DEPTH];
   logic [bffa_pkg::QUEUE_AW-1:0]       wp_ff, rp_ff;
   logic [bffa_pkg::QUEUE_AW:0]         cnt_ff, cnt_in;
   bffa_pkg::cmd_type                   cls;
   logic                                push, pop;

   // classify the incoming word
   always_comb begin
      cls.count = req_bus.word_count;
      cls.index = req_bus.block_index;
      if (req_bus.op == bffa_pkg::OP_ALLOC) begin
         if (req_bus.word_count == '0 || 32'(req_bus.word_count) > HEAP_WORDS) begin
            cls.kind  = bffa_pkg::CMD_REJECT;
            cls.index = '0;
         end else begin
            cls.kind = bffa_pkg::CMD_ALLOC;
         end
      end else begin
         if (32'(req_bus.block_index) >= HEAP_WORDS) begin
            cls.kind = bffa_pkg::CMD_REJECT;
         end else begin
            cls.kind = bffa_pkg::CMD_FREE;
         end
      end
   end

   assign req_bus.ready = (cnt_ff != (bffa_pkg::QUEUE_AW+1)'(bffa_pkg::QUEUE_DEPTH))
                          && !status.clearing;
   assign push   = req_bus.valid && req_bus.ready;
   assign pop    = status.take;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // queue pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (pop) begin
            rp_ff <= rp_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= cls;
      end
   end

   assign head.valid = (cnt_ff != '0);
   assign head.cmd   = q_ff[rp_ff];
endmodule

### rtl/bffa_back.sv
// back end: map clearing, first-fit scan, block marking and freeing
module bffa_back #(
   parameter int HEAP_WORDS = bffa_pkg::HEAP_WORDS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bffa_pkg::queue_head_type   head,
   output bffa_pkg::back_status_type  status,
   bffa_rsp_if.source                 rsp_bus
);
   localparam int RB   = bffa_pkg::ROW_BITS;
   localparam int RS   = bffa_pkg::ROW_SHIFT;
   localparam int ROWS = (HEAP_WORDS + RB - 1) / RB;
   localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int PW   = RAW + RS;
   localparam int RW   = PW + 1;
   localparam int CMW  = (RW > bffa_pkg::COUNT_W) ? RW : bffa_pkg::COUNT_W;
   localparam logic [RAW-1:0] LAST_ROW = RAW'(ROWS - 1);

   typedef enum logic [6:0] {
      ST_CLEAR   = 7'b0000001,
      ST_IDLE    = 7'b0000010,
      ST_SCAN    = 7'b0000100,
      ST_MARK_RD = 7'b0001000,
      ST_MARK_WR = 7'b0010000,
      ST_FREE_RD = 7'b0100000,
      ST_FREE_WR = 7'b1000000
   } state_type;

   state_type                      state_ff;
   logic [RAW-1:0]                 row_ff, ev_row_ff;
   logic                           rd_vld_ff;
   logic [RW-1:0]                  run_ff;
   logic [bffa_pkg::COUNT_W-1:0]   count_ff;
   logic [bffa_pkg::INDEX_W-1:0]   index_ff;
   logic [RS-1:0]                  lo_ff;
   logic [PW-1:0]                  start_ff, end_ff;
   logic                           rsp_valid_ff, rsp_ok_ff;
   logic [bffa_pkg::INDEX_W-1:0]   rsp_idx_ff;

   logic                           ram_we;
   logic [2*RB-1:0]                ram_wdata, ram_rdata;
   logic [RB-1:0]                  rd_used, rd_end;
   logic                           take;

   // scan results
   logic [RB-1:0]                  u, hitv;
   logic [RW-1:0]                  run_last;
   logic                           hit_any;
   logic [RS-1:0]                  hb;
   logic [PW-1:0]                  hit_pos, hit_start;
   logic [CMW-1:0]                 sp;
   // mark and free results
   logic [RB-1:0]                  mk_used, mk_end, fr_mask;
   logic                           fr_hit;

   assign rd_used = ram_rdata[RB-1:0];
   assign rd_end  = ram_rdata[2*RB-1:RB];

   bffa_ram #(.WIDTH(2*RB), .DEPTH(ROWS)) u_map (
      .clock (clock),
      .we    (ram_we),
      .addr  (row_ff),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // free-run search over one map row
   always_comb begin
      logic          has;
      logic [RS-1:0] k;
      logic [RW-1:0] runb;
      logic [PW-1:0] pos;
      run_last = '0;
      for (int b = 0; b < RB; b++) begin
         pos  = {ev_row_ff, RS'(b)};
         u[b] = rd_used[b] || ((PW+1)'(pos) >= (PW+1)'(HEAP_WORDS));
      end
      for (int b = 0; b < RB; b++) begin
         has = 1'b0;
         k   = '0;
         for (int j = 0; j <= b; j++) begin
            if (u[j]) begin
               has = 1'b1;
               k   = RS'(j);
            end
         end
         if (u[b]) begin
            runb = '0;
         end else if (has) begin
            runb = RW'(b) - RW'(k);
         end else begin
            runb = run_ff + RW'(b + 1);
         end
         hitv[b] = !u[b] && (CMW'(runb) >= CMW'(count_ff));
         if (b == RB - 1) begin
            run_last = runb;
         end
      end
      hit_any = |hitv;
      hb      = '0;
      for (int b = RB - 1; b >= 0; b--) begin
         if (hitv[b]) begin
            hb = RS'(b);
         end
      end
      hit_pos   = {ev_row_ff, hb};
      sp        = CMW'(hit_pos) + CMW'(1) - CMW'(count_ff);
      hit_start = sp[PW-1:0];
   end

   // new row contents for marking a block
   always_comb begin
      logic [PW-1:0] pos;
      logic          in_blk;
      for (int b = 0; b < RB; b++) begin
         pos        = {row_ff, RS'(b)};
         in_blk     = (pos >= start_ff) && (pos <= end_ff);
         mk_used[b] = rd_used[b] || in_blk;
         mk_end[b]  = in_blk ? (pos == end_ff) : rd_end[b];
      end
   end

   // words cleared by a free within one row
   always_comb begin
      logic seen;
      for (int b = 0; b < RB; b++) begin
         seen = 1'b0;
         for (int j = 0; j < b; j++) begin
            if (rd_end[j] && (RS'(j) >= lo_ff)) begin
               seen = 1'b1;
            end
         end
         fr_mask[b] = (RS'(b) >= lo_ff) && !seen;
      end
      fr_hit = |(rd_end & fr_mask);
   end

   // memory write port
   always_comb begin
      ram_we    = 1'b0;
      ram_wdata = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
         end
         ST_MARK_WR: begin
            ram_we    = 1'b1;
            ram_wdata = {mk_end, mk_used};
         end
         ST_FREE_WR: begin
            ram_we    = 1'b1;
            ram_wdata = {rd_end & ~fr_mask, rd_used & ~fr_mask};
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   assign take            = (state_ff == ST_IDLE) && head.valid && !rsp_valid_ff;
   assign status.take     = take;
   assign status.clearing = (state_ff == ST_CLEAR);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               if (row_ff == LAST_ROW) begin
                  row_ff   <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  row_ff <= row_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (take) begin
                  case (head.cmd.kind)
                     bffa_pkg::CMD_ALLOC: begin
                        count_ff  <= head.cmd.count;
                        row_ff    <= '0;
                        run_ff    <= '0;
                        rd_vld_ff <= 1'b0;
                        state_ff  <= ST_SCAN;
                     end
                     bffa_pkg::CMD_FREE: begin
                        index_ff <= head.cmd.index;
                        row_ff   <= RAW'(head.cmd.index >> RS);
                        lo_ff    <= head.cmd.index[RS-1:0];
                        state_ff <= ST_FREE_RD;
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_ok_ff    <= 1'b0;
                        rsp_idx_ff   <= head.cmd.index;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               if (row_ff != LAST_ROW) begin
                  row_ff <= row_ff + 1'b1;
               end
               ev_row_ff <= row_ff;
               rd_vld_ff <= 1'b1;
               if (rd_vld_ff) begin
                  if (hit_any) begin
                     start_ff <= hit_start;
                     end_ff   <= hit_pos;
                     row_ff   <= hit_start[PW-1:RS];
                     state_ff <= ST_MARK_RD;
                  end else begin
                     run_ff <= run_last;
                     if (ev_row_ff == LAST_ROW) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_ok_ff    <= 1'b0;
                        rsp_idx_ff   <= '0;
                        state_ff     <= ST_IDLE;
                     end
                  end
               end
            end
            ST_MARK_RD: begin
               state_ff <= ST_MARK_WR;
            end
            ST_MARK_WR: begin
               if (row_ff == end_ff[PW-1:RS]) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ok_ff    <= 1'b1;
                  rsp_idx_ff   <= bffa_pkg::INDEX_W'(start_ff);
                  state_ff     <= ST_IDLE;
               end else begin
                  row_ff   <= row_ff + 1'b1;
                  state_ff <= ST_MARK_RD;
               end
            end
            ST_FREE_RD: begin
               state_ff <= ST_FREE_WR;
            end
            ST_FREE_WR: begin
               lo_ff <= '0;
               if (fr_hit || row_ff == LAST_ROW) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ok_ff    <= 1'b1;
                  rsp_idx_ff   <= index_ff;
                  state_ff     <= ST_IDLE;
               end else begin
                  row_ff   <= row_ff + 1'b1;
                  state_ff <= ST_FREE_RD;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.ok          = rsp_ok_ff;
   assign rsp_bus.start_index = rsp_idx_ff;
endmodule

### rtl/bitmap_first_fit_word_allocator.sv
// Top level of the bitmap first-fit word allocator.
// Allocate: one 32-word map row per cycle over up to R = ceil(HEAP_WORDS/32) rows,
// then a read and a write-back of each map row touched by the new block.
// Free: a read-modify-write of each map row touched, through the single map port.
// Rejected requests skip the map; a two-entry queue takes words while one is busy.
// After reset both maps are cleared row by row, during which req_bus.ready stays low.
module bitmap_first_fit_word_allocator #(
   parameter int HEAP_WORDS = bffa_pkg::HEAP_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   bffa_req_if.sink    req_bus,
   bffa_rsp_if.source  rsp_bus
);
   bffa_pkg::queue_head_type  head;
   bffa_pkg::back_status_type status;

   bffa_front #(.HEAP_WORDS(HEAP_WORDS)) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .status  (status),
      .head    (head)
   );

   bffa_back #(.HEAP_WORDS(HEAP_WORDS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .status  (status),
      .rsp_bus (rsp_bus)
   );
endmodule

### rtl/bffa_checker.sv
// port-level checker for the allocator and its bind
module bffa_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_ok,
   input logic [bffa_pkg::INDEX_W-1:0] rsp_start_index
);
   logic [3:0] pend_ff;

   // words accepted but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + 4'(req_valid && req_ready) - 4'(rsp_valid && rsp_ready);
      end
   end

   // maps are being cleared right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready) else $error("request taken during map clear");

   // no answer without an outstanding request
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != '0)) else $error("response without request");

   // response held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");

   // stalled response payload stable
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_ok) && $stable(rsp_start_index))
      else $error("response payload changed while stalled");
endmodule

bind bitmap_first_fit_word_allocator bffa_checker u_bffa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_ok          (rsp_bus.ok),
   .rsp_start_index (rsp_bus.start_index)
);
